[rtl/core/nar_pkg.sv]
// Shared constants for the note arpeggiator: defaults, request and register codes, limits.
`default_nettype none
package nar_pkg;

  localparam int MAX_HELD_DEF    = 16;
  localparam int SEQ_DEPTH_DEF   = 128;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 32;

  localparam int NOTE_W = 7;
  localparam int STEP_W = 8;
  localparam int REQ_W  = 3;
  localparam int CFG_W  = 21;
  localparam int CFG_AW = 2;

  localparam logic [STEP_W-1:0] OCTAVE_SEMIS = 8'd12;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd4;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_ARP_MODE    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_OCTAVE_SPAN = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PHASE_INC   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GATE_LEVEL  = 2'd3;

  // Arpeggio modes
  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UPDOWN = 2'd2;
  localparam logic [1:0] MODE_PLAYED = 2'd3;

  // Reset values and legal ranges
  localparam logic [2:0]  SPAN_RST = 3'd1;
  localparam logic [2:0]  SPAN_MIN = 3'd1;
  localparam logic [2:0]  SPAN_MAX = 3'd4;
  localparam logic [20:0] INC_RST  = 21'd389566;
  localparam logic [20:0] INC_MIN  = 21'd9739;
  localparam logic [20:0] INC_MAX  = 21'd1947831;
  localparam logic [15:0] GATE_RST = 16'd32768;
  localparam logic [15:0] GATE_MIN = 16'd6554;
  localparam logic [15:0] GATE_MAX = 16'd58982;

endpackage
`default_nettype wire

[rtl/core/nar_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module nar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/note_arpeggiator.sv]
// Note arpeggiator top level: held-note list, step sequence rebuild and stereo gate.
//
// Usage:
//   s_* channel carries requests: tuser = req_type (tick, note on, note off, start,
//   stop); tdata = note_number, sample_left, sample_right from the lowest bit up.
//   m_* channel returns one transaction per request: gated or passed samples, the
//   note at the current step, note_valid and gate_open.
//   cfg_we/cfg_addr/cfg_data write arp_mode, octave_span, phase_increment and
//   gate_level (saturated to their legal ranges); each write rebuilds the
//   step sequence, so write only while the block is idle.
// Sequencing:
//   One request at a time; s_tready is low until its result is loaded.
//   Tick on a running arpeggio with notes held: add, gate, step read, load; other
//   ticks, start, stop and unknown requests: step read, load.
//   Note on: a read and a check per list entry moved by the insertion; note off: a
//   read and a check per held entry, then the rebuild.
//   Rebuild: a read and a write per sequence step generated (held notes times
//   octaves, about twice that in up-down mode), each step going through the single
//   read port of the held-note RAM. A config write costs one rebuild.
// Reset: rst (synchronous) empties the list and sequence, stops, and loads the
//   register defaults; no RAM clearing pass is needed.
// Stall: a result waits in the output register while m_tready is low; the
//   next result holds in the sequencer until the register is free.
`default_nettype none
module note_arpeggiator
  import nar_pkg::*;
#(
  parameter int MAX_HELD    = MAX_HELD_DEF,
  parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  localparam int IN_W  = ((NOTE_W + 2*SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2*SAMPLE_BITS + STEP_W + 2 + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  // note_number, sample_left, sample_right, zero fill
  input  wire logic [IN_W-1:0]   s_tdata,
  // req_type
  input  wire logic [REQ_W-1:0]  s_tuser,
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  // out_left, out_right, current_note, note_valid, gate_open, zero fill
  output      logic [OUT_W-1:0]  m_tdata,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int HAW = $clog2(MAX_HELD);
  localparam int HCW = $clog2(MAX_HELD + 1);
  localparam int SAW = $clog2(SEQ_DEPTH);
  localparam int SCW = $clog2(SEQ_DEPTH + 1);
  localparam int SB  = SAMPLE_BITS;
  localparam int PB  = PHASE_BITS;
  localparam int SHL = (PB >= 32) ? PB - 32 : 0;
  localparam int SHR = (PB < 32) ? 32 - PB : 0;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_TICK_ADD  = 4'd1;
  localparam logic [3:0] ST_TICK_GATE = 4'd2;
  localparam logic [3:0] ST_INS_RD    = 4'd3;
  localparam logic [3:0] ST_INS_CHK   = 4'd4;
  localparam logic [3:0] ST_OFF_RD    = 4'd5;
  localparam logic [3:0] ST_OFF_CHK   = 4'd6;
  localparam logic [3:0] ST_RB_START  = 4'd7;
  localparam logic [3:0] ST_RB_RD     = 4'd8;
  localparam logic [3:0] ST_RB_WR     = 4'd9;
  localparam logic [3:0] ST_RB_FIX    = 4'd10;
  localparam logic [3:0] ST_OUT_RD    = 4'd11;
  localparam logic [3:0] ST_OUT_SEND  = 4'd12;

  // Configuration registers
  logic [1:0]  arp_mode;
  logic [2:0]  octave_span;
  logic [20:0] phase_inc;
  logic [15:0] gate_level;

  // Sequencer state
  logic [3:0]        state;
  logic [NOTE_W-1:0] note;
  logic [SB-1:0]     lft;
  logic [SB-1:0]     rgt;
  logic              gate;
  logic              from_cfg;
  logic [HCW-1:0]    held_cnt;
  logic [HCW-1:0]    i;
  logic [HCW-1:0]    j;
  logic [1:0]        oct;
  logic              desc;
  logic              pass2;
  logic [SCW-1:0]    step_cnt;
  logic [SAW-1:0]    step_idx;
  logic [PB-1:0]     phase;
  logic              running;

  // RAM ports
  logic              h_we;
  logic [HAW-1:0]    h_waddr;
  logic [NOTE_W-1:0] h_wdata;
  logic [HAW-1:0]    h_raddr;
  logic [NOTE_W-1:0] h_rdata;
  logic              st_we;
  logic [STEP_W-1:0] st_wdata;
  logic [STEP_W-1:0] st_rdata;

  logic [63:0]    inc_wide;
  logic [PB-1:0]  inc_scaled;
  logic [PB:0]    sum;
  logic [1:0]     last_oct;
  logic [1:0]     top_oct;
  logic [HCW-1:0] held_m1;
  logic [HCW-1:0] held_m2;
  logic [HCW-1:0] i_m1;
  logic [SAW:0]   idx_inc;
  logic           accept;
  logic           out_free;

  nar_ram #(.WIDTH(NOTE_W), .DEPTH(MAX_HELD)) u_held (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  nar_ram #(.WIDTH(STEP_W), .DEPTH(SEQ_DEPTH)) u_steps (
    .clk   (clk),
    .we    (st_we),
    .waddr (step_cnt[SAW-1:0]),
    .wdata (st_wdata),
    .raddr (step_idx),
    .rdata (st_rdata)
  );

  assign s_tready = (state == ST_IDLE) && !cfg_we;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Phase increment scaled to the accumulator width, then one shared adder
  assign inc_wide   = ({43'd0, phase_inc} << SHL) >> SHR;
  assign inc_scaled = inc_wide[PB-1:0];
  assign sum        = {1'b0, phase} + {1'b0, inc_scaled};
  assign idx_inc    = {1'b0, step_idx} + 1'b1;

  assign top_oct  = 2'(octave_span - 3'd1);
  assign last_oct = (arp_mode == MODE_PLAYED) ? 2'd0 : top_oct;
  assign held_m1  = held_cnt - 1'b1;
  assign held_m2  = held_cnt - 2'd2;
  assign i_m1     = i - 1'b1;

  // Held-list and step-store port control
  always_comb begin
    h_we     = 1'b0;
    h_waddr  = i[HAW-1:0];
    h_wdata  = note;
    h_raddr  = i[HAW-1:0];
    st_we    = 1'b0;
    st_wdata = 8'({1'b0, h_rdata} + 8'(oct) * OCTAVE_SEMIS);
    case (state)
      ST_INS_RD: begin
        if (i == '0) begin
          h_we = 1'b1;
        end else begin
          h_raddr = i_m1[HAW-1:0];
        end
      end
      ST_INS_CHK: begin
        h_we    = 1'b1;
        h_wdata = (h_rdata > note) ? h_rdata : note;
      end
      ST_OFF_CHK: begin
        h_we    = (h_rdata != note);
        h_waddr = j[HAW-1:0];
        h_wdata = h_rdata;
      end
      ST_RB_WR: begin
        st_we = (step_cnt < SCW'(SEQ_DEPTH));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      held_cnt    <= '0;
      step_cnt    <= '0;
      step_idx    <= '0;
      phase       <= '0;
      running     <= 1'b0;
      m_tvalid    <= 1'b0;
      arp_mode    <= MODE_UP;
      octave_span <= SPAN_RST;
      phase_inc   <= INC_RST;
      gate_level  <= GATE_RST;
      from_cfg    <= 1'b0;
    end else begin
      // Drop the valid once taken, unless a new result loads in this cycle
      if (m_tvalid && m_tready && state != ST_OUT_SEND) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            // Saturate each register into its legal range, then rebuild
            case (cfg_addr)
              REG_ARP_MODE: arp_mode <= cfg_data[1:0];
              REG_OCTAVE_SPAN: begin
                if (cfg_data[2:0] < SPAN_MIN) begin
                  octave_span <= SPAN_MIN;
                end else if (cfg_data[2:0] > SPAN_MAX) begin
                  octave_span <= SPAN_MAX;
                end else begin
                  octave_span <= cfg_data[2:0];
                end
              end
              REG_PHASE_INC: begin
                if (cfg_data < INC_MIN) begin
                  phase_inc <= INC_MIN;
                end else if (cfg_data > INC_MAX) begin
                  phase_inc <= INC_MAX;
                end else begin
                  phase_inc <= cfg_data;
                end
              end
              REG_GATE_LEVEL: begin
                if (cfg_data[15:0] < GATE_MIN) begin
                  gate_level <= GATE_MIN;
                end else if (cfg_data[15:0] > GATE_MAX) begin
                  gate_level <= GATE_MAX;
                end else begin
                  gate_level <= cfg_data[15:0];
                end
              end
              default: begin
              end
            endcase
            from_cfg <= 1'b1;
            state    <= ST_RB_START;
          end else if (accept) begin
            note     <= s_tdata[NOTE_W-1:0];
            lft      <= s_tdata[NOTE_W +: SB];
            rgt      <= s_tdata[NOTE_W+SB +: SB];
            gate     <= 1'b0;
            from_cfg <= 1'b0;
            i        <= '0;
            j        <= '0;
            case (s_tuser)
              REQ_TICK: begin
                state <= (running && held_cnt != '0) ? ST_TICK_ADD : ST_OUT_RD;
              end
              REQ_NOTE_ON: begin
                // A full list drops the note but still rebuilds
                i     <= held_cnt;
                state <= (held_cnt < HCW'(MAX_HELD)) ? ST_INS_RD : ST_RB_START;
              end
              REQ_NOTE_OFF: state <= ST_OFF_RD;
              REQ_START: begin
                running  <= 1'b1;
                step_idx <= '0;
                phase    <= '0;
                state    <= ST_OUT_RD;
              end
              REQ_STOP: begin
                running <= 1'b0;
                state   <= ST_OUT_RD;
              end
              default: state <= ST_OUT_RD;
            endcase
          end
        end

        ST_TICK_ADD: begin
          phase <= sum[PB-1:0];
          // Carry out of the phase advances the step
          if (sum[PB] && step_cnt != '0) begin
            step_idx <= (SCW'(idx_inc) == step_cnt) ? '0 : idx_inc[SAW-1:0];
          end
          state <= ST_TICK_GATE;
        end

        ST_TICK_GATE: begin
          gate <= (phase[PB-1 -: 16] < gate_level);
          if (!(phase[PB-1 -: 16] < gate_level)) begin
            lft <= '0;
            rgt <= '0;
          end
          state <= ST_OUT_RD;
        end

        // Insertion sort: shift larger notes up one place
        ST_INS_RD: begin
          if (i == '0) begin
            held_cnt <= held_cnt + 1'b1;
            state    <= ST_RB_START;
          end else begin
            state <= ST_INS_CHK;
          end
        end

        ST_INS_CHK: begin
          if (h_rdata > note) begin
            i     <= i - 1'b1;
            state <= ST_INS_RD;
          end else begin
            held_cnt <= held_cnt + 1'b1;
            state    <= ST_RB_START;
          end
        end

        // Compaction: keep every entry that differs from the released note
        ST_OFF_RD: begin
          if (i == held_cnt) begin
            held_cnt <= j;
            if (j == '0) begin
              running <= 1'b0;
            end
            state <= ST_RB_START;
          end else begin
            state <= ST_OFF_CHK;
          end
        end

        ST_OFF_CHK: begin
          if (h_rdata != note) begin
            j <= j + 1'b1;
          end
          i     <= i + 1'b1;
          state <= ST_OFF_RD;
        end

        ST_RB_START: begin
          step_cnt <= '0;
          pass2    <= 1'b0;
          if (held_cnt == '0) begin
            state <= ST_RB_FIX;
          end else begin
            if (arp_mode == MODE_DOWN) begin
              desc <= 1'b1;
              oct  <= top_oct;
              i    <= held_m1;
            end else begin
              desc <= 1'b0;
              oct  <= 2'd0;
              i    <= '0;
            end
            state <= ST_RB_RD;
          end
        end

        ST_RB_RD: state <= ST_RB_WR;

        ST_RB_WR: begin
          if (step_cnt < SCW'(SEQ_DEPTH)) begin
            step_cnt <= step_cnt + 1'b1;
          end
          state <= ST_RB_RD;
          if (!desc) begin
            if (i == held_m1) begin
              i <= '0;
              if (oct == last_oct) begin
                // Up-down continues downward without the top note
                if (arp_mode == MODE_UPDOWN && held_cnt >= HCW'(2)) begin
                  desc  <= 1'b1;
                  pass2 <= 1'b1;
                  oct   <= top_oct;
                  i     <= held_m2;
                end else begin
                  state <= ST_RB_FIX;
                end
              end else begin
                oct <= oct + 1'b1;
              end
            end else begin
              i <= i + 1'b1;
            end
          end else begin
            if (i == '0) begin
              if (oct == 2'd0) begin
                state <= ST_RB_FIX;
              end else begin
                oct <= oct - 1'b1;
                i   <= pass2 ? held_m2 : held_m1;
              end
            end else begin
              i <= i - 1'b1;
            end
          end
        end

        ST_RB_FIX: begin
          if (SCW'(step_idx) >= step_cnt) begin
            step_idx <= '0;
          end
          state <= from_cfg ? ST_IDLE : ST_OUT_RD;
        end

        ST_OUT_RD: state <= ST_OUT_SEND;

        ST_OUT_SEND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({gate, (step_cnt != '0),
                                ((step_cnt != '0) ? st_rdata : 8'd0), rgt, lft});
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/nar_checker.sv]
// Port-level checker for the note arpeggiator, bound to the top level.
`default_nettype none
module nar_checker #(
  parameter int SAMPLE_BITS = 24,
  parameter int OUT_W       = 64
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  localparam int NB = 2*SAMPLE_BITS;

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // One request at a time: busy right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after accepting a request");

  // An empty sequence reports note 0
  a_empty_note: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[NB+8]) |-> (m_tdata[NB+7:NB] == 8'd0))
    else $error("note reported with empty sequence");

  // Notes never exceed top note plus three octaves
  a_note_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[NB+7:NB] <= 8'd163))
    else $error("note out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind note_arpeggiator nar_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .OUT_W       (OUT_W)
) u_nar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

[sim/note_arpeggiator_tb.sv]
// Self-checking testbench for the note arpeggiator: held list, step sequence and stereo gate.
`default_nettype none
module note_arpeggiator_tb;
  import nar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 56;
  localparam int OUT_W = 64;

  // One result transaction, unpacked from m_tdata
  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [7:0]  note;
    logic        valid;
    logic        gate;
  } arp_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // note_number, sample_left, sample_right, zero fill
  logic [IN_W-1:0]  s_tdata = '0;
  // req_type
  logic [REQ_W-1:0] s_tuser = REQ_TICK;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // out_left, out_right, current_note, note_valid, gate_open, zero fill
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_ARP_MODE;
  logic [CFG_W-1:0] cfg_data = '0;

  note_arpeggiator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit: the slowest legal run is far below this
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Arpeggiator state as predicted from the accepted transactions
  // ---------------------------------------------------------------------------
  logic [6:0]  held_notes [16];
  int          n_held;
  logic [7:0]  seq_notes [128];
  int          seq_len;
  int          seq_pos;
  logic [31:0] phase;
  logic        running;
  logic [1:0]  mode;
  int          span;
  logic [20:0] phase_inc;
  logic [15:0] gate_lvl;

  arp_result_t pending_results[$];
  int          error_count = 0;
  bit          calm = 1'b0;   // suppress random idling on both sides

  function automatic void push_step(int v);
    if (seq_len < 128) begin
      seq_notes[seq_len] = 8'(v);
      seq_len++;
    end
  endfunction

  // Rebuild the step sequence from the held list, mode and octave span
  function automatic void rebuild_steps();
    int o;
    int i;
    seq_len = 0;
    if (n_held > 0) begin
      case (mode)
        MODE_UP, MODE_UPDOWN: begin
          for (o = 0; o < span; o++)
            for (i = 0; i < n_held; i++) push_step(held_notes[i] + 12 * o);
          // on the way down skip the top note so it does not repeat
          if (mode == MODE_UPDOWN)
            for (o = span - 1; o >= 0; o--)
              for (i = n_held - 2; i >= 0; i--) push_step(held_notes[i] + 12 * o);
        end
        MODE_DOWN: begin
          for (o = span - 1; o >= 0; o--)
            for (i = n_held - 1; i >= 0; i--) push_step(held_notes[i] + 12 * o);
        end
        default: begin
          for (i = 0; i < n_held; i++) push_step(held_notes[i]);
        end
      endcase
    end
    if (seq_pos >= seq_len) seq_pos = 0;
  endfunction

  function automatic void reset_arp_state();
    n_held = 0;
    seq_len = 0;
    seq_pos = 0;
    phase = '0;
    running = 1'b0;
    mode = MODE_UP;
    span = SPAN_RST;
    phase_inc = INC_RST;
    gate_lvl = GATE_RST;
  endfunction

  // Advance the predicted state by one request and return the expected result
  function automatic arp_result_t advance_arp(logic [2:0] req, logic [6:0] note,
                                              logic [23:0] l, logic [23:0] r);
    arp_result_t res;
    logic [32:0] sum;
    int i;
    int j;
    res.gate = 1'b0;
    case (req)
      REQ_TICK: begin
        if (running && n_held > 0) begin
          sum = {1'b0, phase} + {12'd0, phase_inc};
          phase = sum[31:0];
          if (sum[32] && seq_len > 0) seq_pos = (seq_pos + 1) % seq_len;
          res.gate = (phase[31:16] < gate_lvl);
          if (!res.gate) begin
            l = '0;
            r = '0;
          end
        end
      end
      REQ_NOTE_ON: begin
        // drop the note when the list is full
        if (n_held < 16) begin
          i = n_held;
          while (i > 0 && held_notes[i-1] > note) begin
            held_notes[i] = held_notes[i-1];
            i--;
          end
          held_notes[i] = note;
          n_held++;
        end
        rebuild_steps();
      end
      REQ_NOTE_OFF: begin
        // remove every copy; an empty list stops the arpeggio
        j = 0;
        for (i = 0; i < n_held; i++)
          if (held_notes[i] != note) begin
            held_notes[j] = held_notes[i];
            j++;
          end
        n_held = j;
        if (n_held == 0) running = 1'b0;
        rebuild_steps();
      end
      REQ_START: begin
        running = 1'b1;
        seq_pos = 0;
        phase = '0;
      end
      REQ_STOP: running = 1'b0;
      default: ;
    endcase
    res.left = l;
    res.right = r;
    res.note = (seq_len > 0) ? seq_notes[seq_pos] : 8'd0;
    res.valid = (seq_len > 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------
  // Drive one request at the falling edge, hold until accepted, record expectation
  task automatic send_req(logic [2:0] req, logic [6:0] note, logic [23:0] l, logic [23:0] r);
    arp_result_t exp_res;
    if (!calm && $urandom_range(99) < 10) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = req;
    s_tdata = {1'b0, r, l, note};
    do @(posedge clk); while (!s_tready);
    exp_res = advance_arp(req, note, l, r);
    pending_results = {pending_results, exp_res};
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_req(REQ_TICK, 7'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write one register while idle; wait out the rebuild it starts
  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      REG_ARP_MODE: mode = value[1:0];
      REG_OCTAVE_SPAN: span = (value[2:0] < SPAN_MIN) ? SPAN_MIN :
                              (value[2:0] > SPAN_MAX) ? SPAN_MAX : value[2:0];
      REG_PHASE_INC: phase_inc = (value < INC_MIN) ? INC_MIN :
                                 (value > INC_MAX) ? INC_MAX : value;
      default: gate_lvl = (value[15:0] < GATE_MIN) ? GATE_MIN :
                          (value[15:0] > GATE_MAX) ? GATE_MAX : value[15:0];
    endcase
    rebuild_steps();
    repeat (300) @(negedge clk);
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 10);
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    arp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[23:0] !== want.left) begin
          $error("out_left: expected %h, got %h", want.left, m_tdata[23:0]);
          error_count++;
        end
        if (m_tdata[47:24] !== want.right) begin
          $error("out_right: expected %h, got %h", want.right, m_tdata[47:24]);
          error_count++;
        end
        if (m_tdata[55:48] !== want.note) begin
          $error("current_note: expected %0d, got %0d", want.note, m_tdata[55:48]);
          error_count++;
        end
        if (m_tdata[56] !== want.valid) begin
          $error("note_valid: expected %b, got %b", want.valid, m_tdata[56]);
          error_count++;
        end
        if (m_tdata[57] !== want.gate) begin
          $error("gate_open: expected %b, got %b", want.gate, m_tdata[57]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Idle behavior: empty list, start with nothing held, unknown requests, sample extremes
  task automatic test_idle_paths();
    send_req(REQ_TICK, 7'd0, 24'h800000, 24'h7FFFFF);
    send_req(REQ_START, 7'd0, 24'hFFFFFF, 24'h000000);
    send_req(REQ_TICK, 7'd127, 24'h7FFFFF, 24'h800000);
    send_req(3'd5, 7'd127, 24'h123456, 24'hABCDEF);
    send_req(3'd6, 7'd64, 24'hFFFFFF, 24'hFFFFFF);
    send_req(3'd7, 7'd1, 24'h000001, 24'h000000);
    send_req(REQ_STOP, 7'd0, 24'h000000, 24'h000000);
  endtask

  // Held list: extremes, duplicates, full list drop, removal of all copies
  task automatic test_held_list();
    int k;
    send_req(REQ_NOTE_ON, 7'd127, 24'h0, 24'h0);
    send_req(REQ_NOTE_ON, 7'd0, 24'h0, 24'h0);
    send_req(REQ_NOTE_ON, 7'd60, 24'h0, 24'h0);
    send_req(REQ_NOTE_ON, 7'd60, 24'h0, 24'h0);
    send_req(REQ_START, 7'd0, 24'h0, 24'h0);
    repeat (4) send_tick();
    send_req(REQ_NOTE_OFF, 7'd60, 24'h0, 24'h0);
    send_tick();
    // fill past the limit so the extra notes are dropped
    for (k = 0; k < 16; k++) send_req(REQ_NOTE_ON, 7'($urandom_range(0, 127)), 24'h0, 24'h0);
    send_tick();
    while (n_held > 0) send_req(REQ_NOTE_OFF, held_notes[n_held-1], 24'h0, 24'h0);
    send_tick();
  endtask

  // Each mode at an alternating span extreme, then at the top span; sequence shrink resets the step
  task automatic test_modes();
    int m;
    int k;
    for (m = 0; m < 4; m++) begin
      write_reg(REG_ARP_MODE, CFG_W'(m) | (CFG_W'($urandom_range(0, 511)) << 2));
      write_reg(REG_OCTAVE_SPAN, (m % 2 == 0) ? 21'd0 : 21'd7);
      for (k = 0; k < 4; k++) send_req(REQ_NOTE_ON, 7'($urandom_range(40, 90)), 24'h0, 24'h0);
      send_req(REQ_START, 7'd0, 24'h0, 24'h0);
      repeat (5) send_tick();
      write_reg(REG_OCTAVE_SPAN, 21'd4);
      while (n_held > 0) send_req(REQ_NOTE_OFF, held_notes[0], 24'h0, 24'h0);
    end
  endtask

  // Runs of ticks at the fastest rate, gate level at its maximum, then crossing a low gate level
  task automatic test_stepping();
    int k;
    write_reg(REG_ARP_MODE, MODE_UPDOWN);
    write_reg(REG_OCTAVE_SPAN, 21'd2);
    write_reg(REG_PHASE_INC, 21'h1FFFFF);
    write_reg(REG_GATE_LEVEL, 21'hFFFF);
    for (k = 0; k < 3; k++) send_req(REQ_NOTE_ON, 7'(50 + 4 * k), 24'h0, 24'h0);
    send_req(REQ_START, 7'd0, 24'h0, 24'h0);
    calm = 1'b1;
    for (k = 0; k < 150; k++) send_tick();
    calm = 1'b0;
    write_reg(REG_GATE_LEVEL, 21'd0);
    for (k = 0; k < 150; k++) send_tick();
    // a large chord then a shrink while deep in the sequence
    for (k = 0; k < 10; k++) send_req(REQ_NOTE_ON, 7'($urandom_range(0, 127)), 24'h0, 24'h0);
    for (k = 0; k < 80; k++) send_tick();
    write_reg(REG_OCTAVE_SPAN, 21'd1);
    send_tick();
    write_reg(REG_PHASE_INC, 21'd0);
    repeat (20) send_tick();
  endtask

  // Random traffic, mostly ticks on a running arpeggio, with one register phase
  task automatic test_random();
    int k;
    int pick;
    logic [6:0] nt;
    for (k = 0; k < 250; k++) begin
      if (k % 200 == 100) begin
        write_reg(REG_ARP_MODE, CFG_W'($urandom));
        write_reg(REG_OCTAVE_SPAN, CFG_W'($urandom_range(0, 7)));
        write_reg(REG_PHASE_INC, ($urandom_range(1) == 1) ? INC_MAX : CFG_W'($urandom));
        write_reg(REG_GATE_LEVEL, CFG_W'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 55) send_tick();
      else if (pick < 73) begin
        nt = ($urandom_range(1) == 1) ? 7'($urandom_range(55, 62)) : 7'($urandom);
        send_req(REQ_NOTE_ON, nt, 24'($urandom), 24'($urandom));
      end else if (pick < 85) begin
        nt = (n_held > 0 && $urandom_range(3) != 0) ?
             held_notes[$urandom_range(0, n_held - 1)] : 7'($urandom);
        send_req(REQ_NOTE_OFF, nt, 24'($urandom), 24'($urandom));
      end else if (pick < 92) send_req(REQ_START, 7'($urandom), 24'($urandom), 24'($urandom));
      else if (pick < 96) send_req(REQ_STOP, 7'($urandom), 24'($urandom), 24'($urandom));
      else send_req(3'($urandom_range(5, 7)), 7'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    reset_arp_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_paths();
    test_held_list();
    test_modes();
    test_stepping();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
